FILE: rtl/arpc_pkg.sv
// ----------------------------------------------------------------------------
// ARP cache package
// Shared widths, operation and register codes, reset values and the
// control/status bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
package arpc_pkg;

    localparam int IP_W   = 32;
    localparam int MAC_W  = 48;
    localparam int AGE_W  = 8;
    localparam int SLOT_W = 5;
    localparam int FUNC_W = 2;
    localparam int LIFE_W = 8;
    localparam int SEED_W = 16;

    // Configuration port: data as wide as the widest register.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // Operation codes carried in the func field.
    localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LIFETIME = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED     = 1'b1;

    localparam logic [LIFE_W-1:0] LIFETIME_RST = 8'd15;
    localparam logic [SEED_W-1:0] SEED_RST     = 16'd44257;
    localparam logic [SEED_W-1:0] LFSR_TAPS    = 16'hB400;
    localparam logic [AGE_W-1:0]  AGE_MAX      = 8'hFF;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;   // register the incoming request
        logic exec;      // search and update the table
        logic load_out;  // move the result into the output register
    } arpc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic rand_wait; // replacement slot not yet computed
    } arpc_status_t;

endpackage

FILE: rtl/arpc_if.sv
// ----------------------------------------------------------------------------
// ARP cache channel interfaces
// Request and response channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface arpc_req_if;
    logic                        valid;
    logic                        ready;
    logic [arpc_pkg::FUNC_W-1:0] func;
    logic [arpc_pkg::IP_W-1:0]   ip_addr;
    logic [arpc_pkg::MAC_W-1:0]  mac_addr;

    modport source (output valid, output func, output ip_addr, output mac_addr,
                    input ready);
    modport sink   (input valid, input func, input ip_addr, input mac_addr,
                    output ready);
endinterface

interface arpc_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        found;
    logic [arpc_pkg::MAC_W-1:0]  mac_found;
    logic [arpc_pkg::SLOT_W-1:0] slot;
    logic                        evicted;

    modport source (output valid, output found, output mac_found, output slot,
                    output evicted, input ready);
    modport sink   (input valid, input found, input mac_found, input slot,
                    input evicted, output ready);
endinterface

FILE: rtl/arpc_ctrl.sv
// ----------------------------------------------------------------------------
// ARP cache controller
// Sequences capture, table search/update and result hand-off.
// ----------------------------------------------------------------------------
module arpc_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_ready,
    output logic                   rsp_valid,
    input  logic                   rsp_ready,
    output arpc_pkg::arpc_cmd_t    cmd,
    input  arpc_pkg::arpc_status_t status
);
    import arpc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    // The output register can take a result when empty or being drained.
    assign out_free  = !out_valid_reg || rsp_ready;
    assign req_ready = (state_reg == ST_IDLE) || ((state_reg == ST_FINISH) && out_free);
    assign rsp_valid = out_valid_reg;

    assign cmd.capture  = req_valid && req_ready;
    assign cmd.exec     = (state_reg == ST_SEARCH) && !status.rand_wait;
    assign cmd.load_out = (state_reg == ST_FINISH) && out_free;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.capture)
                begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (cmd.exec)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = cmd.capture ? ST_SEARCH : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: rtl/arpc_rand.sv
// ----------------------------------------------------------------------------
// ARP cache replacement slot generator
// Galois LFSR with a two-stage pipeline that reduces its next value modulo
// the table size by a reciprocal multiplication.
// ----------------------------------------------------------------------------
module arpc_rand #(
    parameter int ENTRIES = 32,
    parameter int IDX_W   = 5
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [arpc_pkg::CFG_IDX_W-1:0]     cfg_idx,
    input  logic [arpc_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               step,
    output logic [IDX_W-1:0]                   rand_slot,
    output logic                               rand_ok
);
    import arpc_pkg::*;

    localparam int PROD_W = SEED_W + 32;
    // floor(2^32 / ENTRIES) + 1 gives an exact quotient for 16-bit values.
    localparam logic [31:0]       RECIP     = 32'((64'd1 << 32) / ENTRIES + 1);
    localparam logic [SEED_W-1:0] ENTRY_CNT = SEED_W'(ENTRIES);

    logic [SEED_W-1:0] lfsr_reg;
    logic [SEED_W-1:0] lfsr_next;
    logic              seed_wr;
    logic [SEED_W-1:0] x_reg;
    logic [PROD_W-1:0] prod_reg;
    logic              s1_valid_reg;
    logic [IDX_W-1:0]  slot_reg;
    logic              ok_reg;
    logic [SEED_W-1:0] quot;
    logic [SEED_W-1:0] rem;

    assign seed_wr = cfg_we && (cfg_idx == CFG_SEED);

    always_comb
    begin
        lfsr_next = lfsr_reg >> 1;
        if (lfsr_reg[0])
        begin
            lfsr_next = lfsr_next ^ LFSR_TAPS;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lfsr_reg <= SEED_RST;
        end
        else if (seed_wr)
        begin
            lfsr_reg <= cfg_data[SEED_W-1:0];
        end
        else if (step)
        begin
            lfsr_reg <= lfsr_next;
        end
    end

    // Remainder stays below ENTRIES, so 16-bit arithmetic is exact here.
    assign quot = prod_reg[PROD_W-1:32];
    assign rem  = x_reg - quot * ENTRY_CNT;

    always_ff @(posedge clk)
    begin
        x_reg    <= lfsr_next;
        prod_reg <= PROD_W'(lfsr_next) * PROD_W'(RECIP);
        slot_reg <= IDX_W'(rem);
    end

    // The candidate is good once both stages hold the current LFSR state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            ok_reg       <= 1'b0;
        end
        else if (seed_wr || step)
        begin
            s1_valid_reg <= 1'b0;
            ok_reg       <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= 1'b1;
            ok_reg       <= s1_valid_reg;
        end
    end

    assign rand_slot = slot_reg;
    assign rand_ok   = ok_reg;

endmodule

FILE: rtl/arpc_datapath.sv
// ----------------------------------------------------------------------------
// ARP cache datapath
// Entry table with parallel address compare, aging, MAC storage and the
// result register.
// ----------------------------------------------------------------------------
module arpc_datapath #(
    parameter int ENTRIES = 32,
    parameter int IDX_W   = 5
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  arpc_pkg::arpc_cmd_t                cmd,
    output arpc_pkg::arpc_status_t             status,
    input  logic [arpc_pkg::FUNC_W-1:0]        req_func,
    input  logic [arpc_pkg::IP_W-1:0]          req_ip,
    input  logic [arpc_pkg::MAC_W-1:0]         req_mac,
    input  logic                               cfg_we,
    input  logic [arpc_pkg::CFG_IDX_W-1:0]     cfg_idx,
    input  logic [arpc_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic [IDX_W-1:0]                   rand_slot,
    input  logic                               rand_ok,
    output logic                               rand_step,
    output logic                               found,
    output logic [arpc_pkg::MAC_W-1:0]         mac_found,
    output logic [arpc_pkg::SLOT_W-1:0]        slot,
    output logic                               evicted
);
    import arpc_pkg::*;

    // Captured request.
    logic [FUNC_W-1:0] func_reg;
    logic [IP_W-1:0]   ip_reg;
    logic [MAC_W-1:0]  mac_reg;

    logic [LIFE_W-1:0] lifetime_reg;

    // Table state.
    logic              valid_reg [ENTRIES];
    logic              valid_next [ENTRIES];
    logic [AGE_W-1:0]  age_reg [ENTRIES];
    logic [AGE_W-1:0]  age_next [ENTRIES];
    logic [IP_W-1:0]   entry_ip_reg [ENTRIES];
    logic [MAC_W-1:0]  mac_mem [ENTRIES];
    logic [MAC_W-1:0]  rd_data_reg;

    // Search results.
    logic [ENTRIES-1:0] match;
    logic [ENTRIES-1:0] free;
    logic               hit;
    logic               free_any;
    logic [IDX_W-1:0]   hit_idx;
    logic [IDX_W-1:0]   free_idx;
    logic [IDX_W-1:0]   pos;
    logic               is_lookup;
    logic               is_insert;
    logic               is_tick;
    logic               need_rand;
    logic               do_insert;
    logic               do_tick;

    // Result of the current item, then the output register.
    logic               res_found_reg;
    logic [IDX_W-1:0]   res_slot_reg;
    logic               res_evicted_reg;
    logic               out_found_reg;
    logic [MAC_W-1:0]   out_mac_reg;
    logic [SLOT_W-1:0]  out_slot_reg;
    logic               out_evicted_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg <= req_func;
            ip_reg   <= req_ip;
            mac_reg  <= req_mac;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lifetime_reg <= LIFETIME_RST;
        end
        else if (cfg_we && (cfg_idx == CFG_LIFETIME))
        begin
            lifetime_reg <= cfg_data[LIFE_W-1:0];
        end
    end

    assign is_lookup = (func_reg == FUNC_LOOKUP);
    assign is_insert = (func_reg == FUNC_INSERT);
    assign is_tick   = (func_reg == FUNC_TICK);

    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            match[i] = valid_reg[i] && (entry_ip_reg[i] == ip_reg);
            free[i]  = !valid_reg[i];
        end
    end

    assign hit      = |match;
    assign free_any = |free;

    // Lowest index wins for both searches.
    always_comb
    begin
        hit_idx  = '0;
        free_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                hit_idx = IDX_W'(i);
            end
            if (free[i])
            begin
                free_idx = IDX_W'(i);
            end
        end
    end

    assign need_rand        = is_insert && !hit && !free_any;
    assign status.rand_wait = need_rand && !rand_ok;
    assign rand_step        = cmd.exec && need_rand;
    assign do_insert        = cmd.exec && is_insert;
    assign do_tick          = cmd.exec && is_tick;

    always_comb
    begin
        if (hit)
        begin
            pos = hit_idx;
        end
        else if (free_any)
        begin
            pos = free_idx;
        end
        else
        begin
            pos = rand_slot;
        end
    end

    always_comb
    begin
        logic [AGE_W-1:0] aged;
        for (int i = 0; i < ENTRIES; i++)
        begin
            aged          = (age_reg[i] == AGE_MAX) ? AGE_MAX : age_reg[i] + 1'b1;
            age_next[i]   = age_reg[i];
            valid_next[i] = valid_reg[i];
            if (do_tick)
            begin
                age_next[i] = aged;
                if (aged >= lifetime_reg)
                begin
                    valid_next[i] = 1'b0;
                end
            end
            if (do_insert && (pos == IDX_W'(i)))
            begin
                age_next[i]   = '0;
                valid_next[i] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                valid_reg[i] <= 1'b0;
                age_reg[i]   <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                valid_reg[i] <= valid_next[i];
                age_reg[i]   <= age_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_insert)
        begin
            entry_ip_reg[pos] <= ip_reg;
        end
    end

    // MAC storage: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (do_insert)
        begin
            mac_mem[pos] <= mac_reg;
        end
        if (cmd.exec && is_lookup)
        begin
            rd_data_reg <= mac_mem[hit_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            res_found_reg   <= is_lookup && hit;
            res_evicted_reg <= need_rand;
            if (is_insert)
            begin
                res_slot_reg <= pos;
            end
            else if (is_lookup)
            begin
                res_slot_reg <= hit_idx;
            end
            else
            begin
                res_slot_reg <= '0;
            end
        end
        if (cmd.load_out)
        begin
            out_found_reg   <= res_found_reg;
            out_mac_reg     <= res_found_reg ? rd_data_reg : '0;
            out_slot_reg    <= SLOT_W'(res_slot_reg);
            out_evicted_reg <= res_evicted_reg;
        end
    end

    assign found     = out_found_reg;
    assign mac_found = out_mac_reg;
    assign slot      = out_slot_reg;
    assign evicted   = out_evicted_reg;

endmodule

FILE: rtl/arp_cache_table_with_aging.sv
// ----------------------------------------------------------------------------
// ARP cache table with aging
// Sequence: capture the request, search and update the table, then load the
// result into the output register; a new request is taken as a result loads.
// An insert that must evict waits after a seed write or a previous eviction
// while the replacement slot pipeline refills.
// Reset: valid bits and ages clear at once, lifetime returns to 15 and the
// LFSR to 44257; there is no clearing pass, so requests are taken right away.
// ----------------------------------------------------------------------------
module arp_cache_table_with_aging #(
    parameter int ENTRIES = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    arpc_req_if.sink                        req,
    arpc_rsp_if.source                      rsp,
    input  logic                            cfg_we,
    input  logic [arpc_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  logic [arpc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import arpc_pkg::*;

    // Slot index width; a table of one entry still needs one bit.
    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    arpc_cmd_t        cmd;
    arpc_status_t     status;
    logic [IDX_W-1:0] rand_slot;
    logic             rand_ok;
    logic             rand_step;

    // The controller owns the handshakes. A new request is taken while the
    // previous result still sits in the output register; the pipeline stalls
    // when that register is full and the sink holds off, or for a replacement slot.
    arpc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd),
        .status    (status)
    );

    // The replacement generator keeps the next random slot ready ahead of time,
    // so a full-table insert waits on the multiply chain only after a seed write or an eviction.
    arpc_rand #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IDX_W)
    ) u_rand (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_data  (cfg_data),
        .step      (rand_step),
        .rand_slot (rand_slot),
        .rand_ok   (rand_ok)
    );

    // The datapath compares the key against every entry in parallel,
    // applies an insert or an aging tick, and reads the MAC store for a hit.
    arpc_datapath #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IDX_W)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .req_func  (req.func),
        .req_ip    (req.ip_addr),
        .req_mac   (req.mac_addr),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_data  (cfg_data),
        .rand_slot (rand_slot),
        .rand_ok   (rand_ok),
        .rand_step (rand_step),
        .found     (rsp.found),
        .mac_found (rsp.mac_found),
        .slot      (rsp.slot),
        .evicted   (rsp.evicted)
    );

endmodule

FILE: test/tb_arp_cache_table_with_aging.sv
// ----------------------------------------------------------------------------
// ARP cache table with aging: self-checking testbench
// Drives lookup, insert, tick and unused-code requests through the request
// channel and checks every response against a behavioral copy of the table.
// The copy keeps its own valid bits, addresses, ages and replacement LFSR.
// A short directed table comes first, then random phases that run under
// a range of lifetime and seed settings.
// ----------------------------------------------------------------------------
module tb_arp_cache_table_with_aging;

    timeunit 1ns;
    timeprecision 1ps;

    import arpc_pkg::*;

    localparam int TABLE_DEPTH = 32;
    localparam int POOL_SIZE   = 48;
    localparam int MAX_PRINTED = 40;

    // The func field has a fourth value that the block must ignore.
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    // A phase setting of this value is replaced by a random legal value.
    localparam int PICK_RANDOM = -1;

    // One response as the block reports it.
    typedef struct packed {
        logic              found;
        logic [MAC_W-1:0]  mac_found;
        logic [SLOT_W-1:0] slot;
        logic              evicted;
    } arp_reply_t;

    localparam arp_reply_t NO_REPLY = '0;

    // One row of the directed table. A row is sent reps times, with the
    // address and the MAC raised by one on each repetition. Rows marked typed
    // carry their response in the table; the others use the predicted one.
    typedef struct packed {
        logic [FUNC_W-1:0] op;
        logic [IP_W-1:0]   ip;
        logic [MAC_W-1:0]  mac;
        logic [7:0]        reps;
        logic              typed;
        arp_reply_t        want;
    } probe_row_t;

    localparam int PROBE_ROWS = 15;

    // The directed part runs with the reset settings: lifetime 15 and the
    // reset seed. The table starts empty, so the first inserts land in the
    // lowest slots. The 30-request fill row leaves the table full, so the two
    // inserts after it must evict through the LFSR.
    localparam probe_row_t PROBE_PLAN [PROBE_ROWS] = '{
        '{FUNC_LOOKUP, 32'h0000_0000, 48'h0, 8'd1, 1'b1, NO_REPLY},
        '{FUNC_LOOKUP, 32'hFFFF_FFFF, 48'h0, 8'd1, 1'b1, NO_REPLY},
        '{FUNC_UNUSED, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 8'd1, 1'b1, NO_REPLY},
        '{FUNC_INSERT, 32'h0000_0000, 48'h0, 8'd1, 1'b1, NO_REPLY},
        '{FUNC_INSERT, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 8'd1, 1'b1,
          '{1'b0, 48'h0, 5'd1, 1'b0}},
        '{FUNC_LOOKUP, 32'hFFFF_FFFF, 48'h0, 8'd1, 1'b1,
          '{1'b1, 48'hFFFF_FFFF_FFFF, 5'd1, 1'b0}},
        '{FUNC_LOOKUP, 32'h0000_0000, 48'h0, 8'd1, 1'b1,
          '{1'b1, 48'h0, 5'd0, 1'b0}},
        '{FUNC_INSERT, 32'hFFFF_FFFF, 48'h1234_5678_9ABC, 8'd1, 1'b1,
          '{1'b0, 48'h0, 5'd1, 1'b0}},
        '{FUNC_LOOKUP, 32'hFFFF_FFFF, 48'h0, 8'd1, 1'b1,
          '{1'b1, 48'h1234_5678_9ABC, 5'd1, 1'b0}},
        '{FUNC_TICK,   32'h0000_0000, 48'h0, 8'd1, 1'b1, NO_REPLY},
        '{FUNC_INSERT, 32'h0A00_0000, 48'h0200_0000_0000, 8'd30, 1'b0, NO_REPLY},
        '{FUNC_INSERT, 32'hC0A8_0101, 48'h5A5A_5A5A_5A5A, 8'd2, 1'b0, NO_REPLY},
        '{FUNC_LOOKUP, 32'h0A00_0005, 48'h0, 8'd1, 1'b0, NO_REPLY},
        '{FUNC_LOOKUP, 32'hC0A8_0102, 48'h0, 8'd1, 1'b0, NO_REPLY},
        '{FUNC_LOOKUP, 32'hFFFF_FFFF, 48'h0, 8'd1, 1'b0, NO_REPLY}
    };

    // Random phases. Phase 0 keeps the reset settings and writes nothing.
    // The lifetime of 255 phase is heavy on ticks so that ages saturate.
    // Zero lifetime and zero seed come together, and the phase after it keeps
    // the LFSR at zero by not writing the seed. The last phase runs with no
    // idling on either side.
    localparam int PHASE_COUNT = 8;
    localparam int PHASE_LIFE  [PHASE_COUNT] =
        '{15, 1, 255, 0, 200, PICK_RANDOM, 15, PICK_RANDOM};
    localparam int PHASE_SEED  [PHASE_COUNT] =
        '{44257, 1, 65535, 0, 0, PICK_RANDOM, 44257, PICK_RANDOM};
    localparam bit PHASE_LOAD_SEED [PHASE_COUNT] = '{0, 1, 1, 1, 0, 1, 1, 1};
    localparam int PHASE_ITEMS [PHASE_COUNT] = '{200, 200, 480, 200, 150, 180, 190, 150};
    localparam int PHASE_TICK_PCT [PHASE_COUNT] = '{8, 5, 60, 1, 6, 7, 8, 6};

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    arpc_req_if req_ch ();
    arpc_rsp_if rsp_ch ();

    arp_cache_table_with_aging #(
        .ENTRIES (TABLE_DEPTH)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req_ch),
        .rsp      (rsp_ch),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data)
    );

    // Behavioral copy of the table and its settings.
    bit                 tbl_valid [TABLE_DEPTH];
    bit [IP_W-1:0]      tbl_ip    [TABLE_DEPTH];
    bit [MAC_W-1:0]     tbl_mac   [TABLE_DEPTH];
    bit [AGE_W-1:0]     tbl_age   [TABLE_DEPTH];
    bit [SEED_W-1:0]    lfsr_copy;
    bit [LIFE_W-1:0]    lifetime_copy;

    // Responses that the accepted requests are still owed, oldest first.
    arp_reply_t awaited_replies [$];

    int mismatch_count;
    bit gaps_on;
    bit calm;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // The run is far shorter than this even with every stall at its longest.
    initial
    begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

    task automatic flag_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("%0t ns: mismatch: %s", $time, what);
    endtask

    // Applies one request to the table copy and returns the response the
    // block must give for it.
    function automatic arp_reply_t expected_arp_reply(input logic [FUNC_W-1:0] op,
                                                      input logic [IP_W-1:0] ip,
                                                      input logic [MAC_W-1:0] mac);
        arp_reply_t reply;
        int         pos;
        int         i;
        bit         low;
        reply = NO_REPLY;
        pos = -1;
        case (op)
            FUNC_LOOKUP:
            begin
                // The lowest valid slot that holds the address wins.
                for (i = 0; i < TABLE_DEPTH; i++)
                begin
                    if (tbl_valid[i] && tbl_ip[i] == ip)
                    begin
                        reply.found = 1'b1;
                        reply.mac_found = tbl_mac[i];
                        reply.slot = SLOT_W'(i);
                        break;
                    end
                end
            end
            FUNC_INSERT:
            begin
                // Same address first, then the lowest free slot.
                for (i = 0; i < TABLE_DEPTH && pos < 0; i++)
                    if (tbl_valid[i] && tbl_ip[i] == ip)
                        pos = i;
                for (i = 0; i < TABLE_DEPTH && pos < 0; i++)
                    if (!tbl_valid[i])
                        pos = i;
                // A full table steps the Galois LFSR once and evicts the slot
                // that its new value picks.
                if (pos < 0)
                begin
                    low = lfsr_copy[0];
                    lfsr_copy = lfsr_copy >> 1;
                    if (low)
                        lfsr_copy = lfsr_copy ^ LFSR_TAPS;
                    pos = int'(lfsr_copy) % TABLE_DEPTH;
                    reply.evicted = 1'b1;
                end
                tbl_ip[pos] = ip;
                tbl_mac[pos] = mac;
                tbl_age[pos] = '0;
                tbl_valid[pos] = 1'b1;
                reply.slot = SLOT_W'(pos);
            end
            FUNC_TICK:
            begin
                // Every age advances, valid or not, and stops at its maximum.
                for (i = 0; i < TABLE_DEPTH; i++)
                begin
                    if (tbl_age[i] != AGE_MAX)
                        tbl_age[i] = tbl_age[i] + 1'b1;
                    if (tbl_age[i] >= lifetime_copy)
                        tbl_valid[i] = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
        return reply;
    endfunction

    // Presents one request, holds it until the block takes it, and records
    // the response it is owed. The caller is always at a rising edge. Valid is
    // left high after acceptance so that back-to-back requests need no edge
    // with valid low.
    task automatic offer_request(input logic [FUNC_W-1:0] op,
                                 input logic [IP_W-1:0] ip,
                                 input logic [MAC_W-1:0] mac,
                                 input bit typed,
                                 input arp_reply_t want);
        arp_reply_t predicted;
        int         gap;
        gap = 0;
        if (gaps_on && !calm && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 6);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.func     <= op;
        req_ch.ip_addr  <= ip;
        req_ch.mac_addr <= mac;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        predicted = expected_arp_reply(op, ip, mac);
        awaited_replies.push_back(typed ? want : predicted);
    endtask

    // Response side: takes responses with random stalls and compares each
    // one with the oldest owed response.
    initial
    begin
        arp_reply_t want;
        int         stall_left;
        int         cycle_count;
        bit         stall_on;
        rsp_ch.ready = 1'b0;
        stall_left = 0;
        cycle_count = 0;
        stall_on = 1'b1;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            begin
                if (awaited_replies.size() == 0)
                    flag_mismatch($sformatf("response with none owed, slot %0d", rsp_ch.slot));
                else
                begin
                    want = awaited_replies.pop_front();
                    if (rsp_ch.found !== want.found)
                        flag_mismatch($sformatf("found %b, want %b",
                                                rsp_ch.found, want.found));
                    if (rsp_ch.mac_found !== want.mac_found)
                        flag_mismatch($sformatf("mac_found %h, want %h",
                                                rsp_ch.mac_found, want.mac_found));
                    if (rsp_ch.slot !== want.slot)
                        flag_mismatch($sformatf("slot %0d, want %0d",
                                                rsp_ch.slot, want.slot));
                    if (rsp_ch.evicted !== want.evicted)
                        flag_mismatch($sformatf("evicted %b, want %b",
                                                rsp_ch.evicted, want.evicted));
                end
            end
            // Stalls come in bursts, and some stretches have none at all.
            cycle_count++;
            if (cycle_count % 100 == 0)
                stall_on = ($urandom_range(0, 2) != 0);
            if (stall_left > 0)
                stall_left--;
            else if (stall_on && !calm && $urandom_range(0, 3) == 0)
                stall_left = $urandom_range(1, 6);
            rsp_ch.ready <= (stall_left == 0);
        end
    end

    // Request side: reset, the directed table, then the random phases.
    initial
    begin
        logic [IP_W-1:0]   addr_pool [POOL_SIZE];
        logic [IP_W-1:0]   ip;
        logic [MAC_W-1:0]  mac;
        logic [FUNC_W-1:0] op;
        logic [LIFE_W-1:0] life;
        logic [SEED_W-1:0] seed;
        int                row;
        int                k;
        int                ph;
        int                n;
        int                pick;

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.func = FUNC_LOOKUP;
        req_ch.ip_addr = '0;
        req_ch.mac_addr = '0;
        mismatch_count = 0;
        gaps_on = 1'b1;
        calm = 1'b0;

        // The copy starts as the block does after reset.
        for (k = 0; k < TABLE_DEPTH; k++)
        begin
            tbl_valid[k] = 1'b0;
            tbl_ip[k] = '0;
            tbl_mac[k] = '0;
            tbl_age[k] = '0;
        end
        lfsr_copy = SEED_RST;
        lifetime_copy = LIFETIME_RST;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. Repeated rows step the address and MAC by one.
        for (row = 0; row < PROBE_ROWS; row++)
            for (k = 0; k < int'(PROBE_PLAN[row].reps); k++)
                offer_request(PROBE_PLAN[row].op,
                              PROBE_PLAN[row].ip + IP_W'(k),
                              PROBE_PLAN[row].mac + MAC_W'(k),
                              PROBE_PLAN[row].typed,
                              PROBE_PLAN[row].want);

        for (ph = 0; ph < PHASE_COUNT; ph++)
        begin
            // Settings change only with the block idle: valid low and every
            // owed response taken. Each request gives exactly one response,
            // so an empty queue means nothing is left in flight.
            if (ph > 0)
            begin
                req_ch.valid <= 1'b0;
                while (awaited_replies.size() != 0)
                    @(posedge clk);
                life = (PHASE_LIFE[ph] == PICK_RANDOM) ?
                       LIFE_W'($urandom_range(1, 255)) : LIFE_W'(PHASE_LIFE[ph]);
                seed = (PHASE_SEED[ph] == PICK_RANDOM) ?
                       SEED_W'($urandom_range(1, 65535)) : SEED_W'(PHASE_SEED[ph]);
                // Write enable stays high across back-to-back writes.
                cfg_we   <= 1'b1;
                cfg_idx  <= CFG_LIFETIME;
                cfg_data <= CFG_DATA_W'(life);
                @(posedge clk);
                lifetime_copy = life;
                if (PHASE_LOAD_SEED[ph])
                begin
                    // A seed write also reloads the LFSR.
                    cfg_idx  <= CFG_SEED;
                    cfg_data <= seed;
                    @(posedge clk);
                    lfsr_copy = seed;
                end
                cfg_we <= 1'b0;
            end

            calm = (ph == PHASE_COUNT - 1);

            // A small pool of addresses keeps lookups hitting and makes
            // inserts refresh, fill and then evict. A tenth of the requests
            // use fresh random addresses as noise.
            for (k = 0; k < POOL_SIZE; k++)
                addr_pool[k] = $urandom;

            for (n = 0; n < PHASE_ITEMS[ph]; n++)
            begin
                if (n % 50 == 0)
                    gaps_on = ($urandom_range(0, 2) != 0);
                pick = $urandom_range(0, 99);
                if ($urandom_range(0, 9) == 0)
                    ip = $urandom;
                else
                    ip = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
                mac = MAC_W'({$urandom, $urandom});
                if (pick < PHASE_TICK_PCT[ph])
                    op = FUNC_TICK;
                else if (pick < PHASE_TICK_PCT[ph] + 3)
                    op = FUNC_UNUSED;
                else if ($urandom_range(0, 1) == 1)
                    op = FUNC_INSERT;
                else
                    op = FUNC_LOOKUP;
                offer_request(op, ip, mac, 1'b0, NO_REPLY);
            end
        end

        // Drain: wait for every owed response, then keep clocking so that a
        // stray extra response would still be caught.
        req_ch.valid <= 1'b0;
        while (awaited_replies.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
